// ===== rtl/tli_pkg.sv =====
// Shared types and constants of the table interpolation and integral block.
// Used by the controller, the datapath and the top level; depends on nothing.
package tli_pkg;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_ORDER
  } status_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_K
  } rd_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SRCH_INIT,
    OP_SRCH_UPD,
    OP_SW_FIRST,
    OP_SEG_LOAD,
    OP_LAST_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_SUM,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_INTERP,
    OP_OUT_ZERO,
    OP_OUT_RES
  } op_e;

  typedef struct packed {
    op_e     op;
    rd_sel_e rd;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic z_lt_data;
    logic z_gt_data;
    logic span_gt1;
    logic order_bad;
    logic k_last;
    logic div_done;
    logic out_free;
  } sts_t;

  localparam int unsigned XW = 32;
  localparam int unsigned IW = 48;
  localparam int unsigned PTS_W = 7;
  localparam logic [PTS_W-1:0] PTS_RESET = 7'd2;
  localparam logic [5:0] DIV_STEPS = 6'd33;
  localparam logic [IW-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [IW-1:0] INTEG_MIN = 48'h8000_0000_0000;

endpackage

// ===== rtl/tli_if.sv =====
// Handshake channels of the table interpolation block: request, result and
// configuration words. Depends on nothing.
interface tli_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [5:0]  entry_index;
  logic signed [31:0] entry_x;
  logic signed [31:0] entry_y;
  logic signed [31:0] query_point;
  modport source (output valid, req_type, entry_index, entry_x, entry_y, query_point,
                  input ready);
  modport sink (input valid, req_type, entry_index, entry_x, entry_y, query_point,
                output ready);
endinterface

interface tli_res_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] interp_value;
  logic signed [47:0] integral_value;
  logic [1:0]  status;
  modport source (output valid, interp_value, integral_value, status, input ready);
  modport sink (input valid, interp_value, integral_value, status, output ready);
endinterface

interface tli_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] points_in_use;
  modport source (output valid, points_in_use, input ready);
  modport sink (input valid, points_in_use, output ready);
endinterface

// ===== rtl/table_linear_interp_integral.sv =====
// Top level of the piecewise-linear table interpolation and integral block.
// Depends on tli_pkg, the channel interfaces, tli_ctrl and tli_dp.
//
// Requests arrive on the req channel. A load word writes one breakpoint (x, y)
// into the table; a query word gives a point z and returns the interpolated
// value, the integral from the first breakpoint to z, and a status. Every
// request produces exactly one word on the res channel. The cfg channel sets
// points_in_use and is always ready; write it only while the block is idle.
// Requests are handled one at a time. A query runs a binary search for the
// segment that holds z, then sweeps from the first breakpoint up to the
// selected segment: each lower segment costs one table read and a two-pass
// 33x32 multiply, and the slope term uses a 33-step restoring divider.
// Range errors are found before the search and return without a sweep.
// The result register lets a new
// request be accepted while the previous result waits; if the receiver
// stalls, the block finishes the next request and holds in its final state.
// Reset clears the control state and sets points_in_use to 2; the table
// contents are undefined until loaded.
module table_linear_interp_integral #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  tli_req_if.sink   req,
  tli_res_if.source res,
  tli_cfg_if.sink   cfg
);

  tli_pkg::cmd_t cmd;
  tli_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_query_i (req.req_type),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg.valid),
    .cfg_data_i       (cfg.points_in_use),
    .req_type_i       (req.req_type),
    .entry_index_i    (req.entry_index),
    .entry_x_i        (req.entry_x),
    .entry_y_i        (req.entry_y),
    .query_point_i    (req.query_point),
    .res_ready_i      (res.ready),
    .res_valid_o      (res.valid),
    .interp_value_o   (res.interp_value),
    .integral_value_o (res.integral_value),
    .status_o         (res.status)
  );

endmodule

// ===== rtl/tli_ctrl.sv =====
// Sequencing state machine of the table interpolation block.
// Depends on tli_pkg; drives the datapath by commands and reads its status.
module tli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_query_i,
  output logic          in_ready_o,
  input  tli_pkg::sts_t sts_i,
  output tli_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_W0, S_WN, S_SRCH, S_SRCH_W, S_SW_FIRST, S_SW_RD, S_SW_W,
    S_MLO, S_MHI, S_MSUM, S_ACC, S_DIV_INIT, S_DIV, S_INTERP, S_OUT_ZERO, S_OUT_RES
  } state_e;

  typedef enum logic [1:0] {
    TAG_SEG,
    TAG_LAST,
    TAG_FINAL
  } tag_e;

  state_e           state_q, state_d;
  tli_pkg::status_e status_q, status_d;
  tag_e             tag_q, tag_d;

  always_comb begin
    state_d       = state_q;
    status_d      = status_q;
    tag_d         = tag_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = tli_pkg::OP_NONE;
    cmd_o.rd      = tli_pkg::RD_NONE;
    cmd_o.status  = status_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tli_pkg::OP_CAPTURE;
          status_d = tli_pkg::ST_OK;
          state_d  = in_query_i ? S_CHK : S_OUT_ZERO;
        end
      end
      S_CHK: begin
        if (sts_i.n_lt2) begin
          status_d = tli_pkg::ST_RANGE;
          state_d  = S_OUT_ZERO;
        end else begin
          cmd_o.rd = tli_pkg::RD_ZERO;
          state_d  = S_W0;
        end
      end
      S_W0: begin
        if (sts_i.z_lt_data) begin
          status_d = tli_pkg::ST_RANGE;
          state_d  = S_OUT_ZERO;
        end else begin
          cmd_o.rd = tli_pkg::RD_LAST;
          state_d  = S_WN;
        end
      end
      S_WN: begin
        if (sts_i.z_gt_data) begin
          status_d = tli_pkg::ST_RANGE;
          state_d  = S_OUT_ZERO;
        end else begin
          cmd_o.op = tli_pkg::OP_SRCH_INIT;
          state_d  = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts_i.span_gt1) begin
          cmd_o.rd = tli_pkg::RD_MID;
          state_d  = S_SRCH_W;
        end else begin
          cmd_o.rd = tli_pkg::RD_ZERO;
          state_d  = S_SW_FIRST;
        end
      end
      S_SRCH_W: begin
        cmd_o.op = tli_pkg::OP_SRCH_UPD;
        state_d  = S_SRCH;
      end
      S_SW_FIRST: begin
        cmd_o.op = tli_pkg::OP_SW_FIRST;
        state_d  = S_SW_RD;
      end
      S_SW_RD: begin
        cmd_o.rd = tli_pkg::RD_K;
        state_d  = S_SW_W;
      end
      S_SW_W: begin
        if (sts_i.order_bad) begin
          status_d = tli_pkg::ST_ORDER;
          state_d  = S_OUT_ZERO;
        end else if (sts_i.k_last) begin
          cmd_o.op = tli_pkg::OP_LAST_LOAD;
          tag_d    = TAG_LAST;
          state_d  = S_MLO;
        end else begin
          cmd_o.op = tli_pkg::OP_SEG_LOAD;
          tag_d    = TAG_SEG;
          state_d  = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.op = tli_pkg::OP_MUL_LO;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = tli_pkg::OP_MUL_HI;
        state_d  = S_MSUM;
      end
      S_MSUM: begin
        cmd_o.op = tli_pkg::OP_MUL_SUM;
        state_d  = (tag_q == TAG_LAST) ? S_DIV_INIT : S_ACC;
      end
      S_ACC: begin
        cmd_o.op = tli_pkg::OP_ACC;
        state_d  = (tag_q == TAG_FINAL) ? S_OUT_RES : S_SW_RD;
      end
      S_DIV_INIT: begin
        cmd_o.op = tli_pkg::OP_DIV_INIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_INTERP;
        end else begin
          cmd_o.op = tli_pkg::OP_DIV_STEP;
        end
      end
      S_INTERP: begin
        cmd_o.op = tli_pkg::OP_INTERP;
        tag_d    = TAG_FINAL;
        state_d  = S_MLO;
      end
      S_OUT_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.op = tli_pkg::OP_OUT_ZERO;
          state_d  = S_IDLE;
        end
      end
      S_OUT_RES: begin
        if (sts_i.out_free) begin
          cmd_o.op = tli_pkg::OP_OUT_RES;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= tli_pkg::ST_OK;
      tag_q    <= TAG_SEG;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      tag_q    <= tag_d;
    end
  end

`ifndef SYNTHESIS
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == tli_pkg::OP_OUT_RES || cmd_o.op == tli_pkg::OP_OUT_ZERO) |-> sts_i.out_free)
    else $error("Result register loaded while occupied.");
  a_interp_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INTERP) |-> ($past(state_q) == S_DIV && $past(sts_i.div_done)))
    else $error("Interpolation started before the division finished.");
  a_div_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_INIT) |-> (tag_q == TAG_LAST))
    else $error("Division started for a product that is not the slope term.");
`endif

endmodule

// ===== rtl/tli_dp.sv =====
// Datapath of the table interpolation block: breakpoint memory, search and
// sweep counters, split multiplier, serial divider, accumulator, result register.
module tli_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tli_pkg::cmd_t      cmd_i,
  output tli_pkg::sts_t      sts_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               req_type_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [31:0] entry_x_i,
  input  logic signed [31:0] entry_y_i,
  input  logic signed [31:0] query_point_i,
  input  logic               res_ready_i,
  output logic               res_valid_o,
  output logic signed [31:0] interp_value_o,
  output logic signed [47:0] integral_value_o,
  output logic [1:0]         status_o
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int ACC_W = 50 + IDX_W;

  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic [6:0]        pts_q;
  logic [CNT_W-1:0]  n_q;
  logic signed [31:0] z_q;
  logic [IDX_W-1:0]  i_q, j_q, mid_q, k_q;
  logic signed [31:0] prev_x_q, prev_y_q, yi_q, interp_q;
  logic [31:0]       dx_q, t_q, mul_b_q;
  logic              dy_neg_q, a_neg_q;
  logic [32:0]       mul_a_q;
  logic [47:0]       p_lo_q;
  logic [48:0]       p_hi_q;
  logic [64:0]       prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [32:0]       rem_q, num_q, quo_q;
  logic [5:0]        div_cnt_q;
  logic              out_valid_q;
  logic signed [31:0] out_interp_q;
  logic signed [47:0] out_integ_q;
  logic [1:0]        out_status_q;

  logic signed [31:0] data_x, data_y;
  logic [PW-1:0]     pts_ext;
  logic [CNT_W-1:0]  n_new;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic signed [32:0] seg_s, seg_w, last_dx, last_dy, last_t;
  logic [32:0]       seg_mag, dy_mag, fin_mag;
  logic [65:0]       round_sum, div_num;
  logic [47:0]       term_mag;
  logic signed [ACC_W-1:0] term;
  logic [33:0]       trial, diff;
  logic              ge;
  logic signed [34:0] iv;
  logic signed [31:0] iv_sat;
  logic signed [32:0] fin_s;
  logic [ACC_W-48:0] acc_top;
  logic signed [47:0] integ_sat;
  logic              out_free;
  logic              load_we;

  assign data_x = signed'(rd_q[63:32]);
  assign data_y = signed'(rd_q[31:0]);

  assign pts_ext = PW'(pts_q);
  assign n_new   = (pts_ext > PW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(pts_ext);
  assign mid_sum = {1'b0, i_q} + {1'b0, j_q};
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    case (cmd_i.rd)
      tli_pkg::RD_ZERO: rd_addr = '0;
      tli_pkg::RD_LAST: rd_addr = IDX_W'(n_q - CNT_W'(1));
      tli_pkg::RD_MID:  rd_addr = mid;
      tli_pkg::RD_K:    rd_addr = k_q;
      default:          rd_addr = '0;
    endcase
  end

  assign seg_s   = {prev_y_q[31], prev_y_q} + {data_y[31], data_y};
  assign seg_w   = {data_x[31], data_x} - {prev_x_q[31], prev_x_q};
  assign seg_mag = seg_s[32] ? 33'(-seg_s) : 33'(seg_s);
  assign last_dx = seg_w;
  assign last_dy = {data_y[31], data_y} - {prev_y_q[31], prev_y_q};
  assign dy_mag  = last_dy[32] ? 33'(-last_dy) : 33'(last_dy);
  assign last_t  = {z_q[31], z_q} - {prev_x_q[31], prev_x_q};

  assign round_sum = {1'b0, prod_q} + 66'h10000;
  assign term_mag  = round_sum[64:17];
  assign term      = a_neg_q ? -signed'(ACC_W'(term_mag)) : signed'(ACC_W'(term_mag));

  assign div_num = {1'b0, prod_q} + {35'b0, dx_q[31:1]};
  assign trial   = {rem_q, num_q[32]};
  assign ge      = trial >= {2'b0, dx_q};
  assign diff    = trial - {2'b0, dx_q};

  assign iv = dy_neg_q ? ({{3{yi_q[31]}}, yi_q} - {2'b0, quo_q})
                       : ({{3{yi_q[31]}}, yi_q} + {2'b0, quo_q});
  always_comb begin
    if (iv[34:31] == 4'b0000 || iv[34:31] == 4'b1111) begin
      iv_sat = iv[31:0];
    end else begin
      iv_sat = iv[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end
  assign fin_s   = {iv_sat[31], iv_sat} + {yi_q[31], yi_q};
  assign fin_mag = fin_s[32] ? 33'(-fin_s) : 33'(fin_s);

  assign acc_top = acc_q[ACC_W-1:47];
  always_comb begin
    if (acc_top == '0 || acc_top == '1) begin
      integ_sat = acc_q[47:0];
    end else begin
      integ_sat = acc_q[ACC_W-1] ? signed'(tli_pkg::INTEG_MIN) : signed'(tli_pkg::INTEG_MAX);
    end
  end

  assign out_free = !out_valid_q || res_ready_i;
  assign load_we  = (cmd_i.op == tli_pkg::OP_CAPTURE) && !req_type_i &&
                    ({26'b0, entry_index_i} < 32'(TABLE_DEPTH));

  assign sts_o.n_lt2     = n_q < CNT_W'(2);
  assign sts_o.z_lt_data = z_q < data_x;
  assign sts_o.z_gt_data = z_q > data_x;
  assign sts_o.span_gt1  = ({1'b0, j_q} - {1'b0, i_q}) > (IDX_W+1)'(1);
  assign sts_o.order_bad = data_x <= prev_x_q;
  assign sts_o.k_last    = {1'b0, k_q} == ({1'b0, i_q} + (IDX_W+1)'(1));
  assign sts_o.div_done  = div_cnt_q == '0;
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[IDX_W'(entry_index_i)] <= {entry_x_i, entry_y_i};
    end
    if (cmd_i.rd != tli_pkg::RD_NONE) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q       <= tli_pkg::PTS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pts_q <= cfg_data_i;
      end
      if (cmd_i.op == tli_pkg::OP_OUT_ZERO || cmd_i.op == tli_pkg::OP_OUT_RES) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd == tli_pkg::RD_MID) begin
      mid_q <= mid;
    end
    case (cmd_i.op)
      tli_pkg::OP_CAPTURE: begin
        z_q   <= query_point_i;
        n_q   <= n_new;
        acc_q <= '0;
      end
      tli_pkg::OP_SRCH_INIT: begin
        i_q <= '0;
        j_q <= IDX_W'(n_q - CNT_W'(1));
      end
      tli_pkg::OP_SRCH_UPD: begin
        if (z_q > data_x) begin
          i_q <= mid_q;
        end else begin
          j_q <= mid_q;
        end
      end
      tli_pkg::OP_SW_FIRST: begin
        prev_x_q <= data_x;
        prev_y_q <= data_y;
        k_q      <= IDX_W'(1);
      end
      tli_pkg::OP_SEG_LOAD: begin
        mul_a_q  <= seg_mag;
        mul_b_q  <= seg_w[31:0];
        a_neg_q  <= seg_s[32];
        prev_x_q <= data_x;
        prev_y_q <= data_y;
        k_q      <= k_q + IDX_W'(1);
      end
      tli_pkg::OP_LAST_LOAD: begin
        yi_q     <= prev_y_q;
        dx_q     <= last_dx[31:0];
        t_q      <= last_t[31:0];
        dy_neg_q <= last_dy[32];
        mul_a_q  <= dy_mag;
        mul_b_q  <= last_t[31:0];
      end
      tli_pkg::OP_MUL_LO: begin
        p_lo_q <= 48'(mul_a_q[15:0]) * 48'(mul_b_q);
      end
      tli_pkg::OP_MUL_HI: begin
        p_hi_q <= 49'(mul_a_q[32:16]) * 49'(mul_b_q);
      end
      tli_pkg::OP_MUL_SUM: begin
        prod_q <= {p_hi_q, 16'b0} + 65'(p_lo_q);
      end
      tli_pkg::OP_ACC: begin
        acc_q <= acc_q + term;
      end
      tli_pkg::OP_DIV_INIT: begin
        rem_q     <= {1'b0, div_num[64:33]};
        num_q     <= div_num[32:0];
        quo_q     <= '0;
        div_cnt_q <= tli_pkg::DIV_STEPS;
      end
      tli_pkg::OP_DIV_STEP: begin
        rem_q     <= ge ? diff[32:0] : trial[32:0];
        quo_q     <= {quo_q[31:0], ge};
        num_q     <= {num_q[31:0], 1'b0};
        div_cnt_q <= div_cnt_q - 6'd1;
      end
      tli_pkg::OP_INTERP: begin
        interp_q <= iv_sat;
        mul_a_q  <= fin_mag;
        mul_b_q  <= t_q;
        a_neg_q  <= fin_s[32];
      end
      tli_pkg::OP_OUT_ZERO: begin
        out_interp_q <= '0;
        out_integ_q  <= '0;
        out_status_q <= cmd_i.status;
      end
      tli_pkg::OP_OUT_RES: begin
        out_interp_q <= interp_q;
        out_integ_q  <= integ_sat;
        out_status_q <= tli_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o      = out_valid_q;
  assign interp_value_o   = out_interp_q;
  assign integral_value_o = out_integ_q;
  assign status_o         = out_status_q;

endmodule
